// File: sv/tut_pkg.sv
// ----------------------------------------------------------------------------
// tut_pkg: shared types and codes of the tag UID table
// Operation and status codes, the sequencer state type and the scan mode
// passed between the sequencer and the entry compare unit.
// ----------------------------------------------------------------------------
package tut_pkg;

   localparam int BYTE_W          = 8;
   localparam int UID_HALF_W      = 40;
   localparam int UID_FIELD_BYTES = 10;
   localparam int UID_FIELD_BITS  = 2 * UID_HALF_W;

   // Operation codes on the request channel.
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // Status codes on the response channel.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_RANGE     = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLEAR = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   // Lookup hits an occupied entry with a matching UID; insert hits a free one.
   typedef enum logic {
      MODE_LOOKUP = 1'b0,
      MODE_INSERT = 1'b1
   } scan_mode_type;

endpackage

// File: sv/tag_uid_table.sv
// ----------------------------------------------------------------------------
// tag_uid_table: table of tag UIDs with first-free insert and prefix lookup
// Sequencer, entry memory and a shared compare unit for lookup, insert
// and delete operations.
// ----------------------------------------------------------------------------
// The table handles one request at a time. A lookup or insert scans the
// entries in ascending order through the single read port of the entry
// memory, one entry per clock, and stops at the first hit or after the
// last entry. A delete or an unused operation code has its response valid
// in the cycle after the request transfer. req_ready is low while a
// request is in work and while a response waits for its transfer. After
// reset the block sweeps every memory entry once to mark every slot free,
// and takes no request during that sweep. A lookup of length zero returns
// the lowest occupied slot; lengths above UID_BYTES count as UID_BYTES.
module tag_uid_table #(
   parameter int ENTRIES   = 64,
   parameter int UID_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [39:0] req_uid_upper,
   input  logic [39:0] req_uid_lower,
   input  logic [3:0]  req_uid_length,
   input  logic [7:0]  req_permission,
   input  logic [5:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_slot_index,
   output logic [7:0]  rsp_found_permission
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int UID_W  = tut_pkg::BYTE_W * UID_BYTES;
   localparam int WORD_W = tut_pkg::BYTE_W + UID_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   tut_pkg::state_type     state_ff, state_in;
   tut_pkg::scan_mode_type mode_ff, mode_in;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;

   logic [UID_BYTES-1:0][7:0] query_ff, query_in;
   logic [3:0]                len_ff, len_in;
   logic [7:0]                perm_ff, perm_in;

   logic [1:0] status_ff, status_in;
   logic [5:0] slot_idx_ff, slot_idx_in;
   logic [7:0] fperm_ff, fperm_in;

   logic [tut_pkg::UID_FIELD_BITS-1:0] uid_full;
   logic [3:0]                         len_sat;
   logic                               req_xfer;
   logic                               rsp_xfer;
   logic                               slot_in_range;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [WORD_W-1:0]  rd_data;
   logic [7:0]                rd_perm;
   logic [UID_BYTES-1:0][7:0] rd_uid;
   logic                      hit;

   assign req_xfer      = req_valid && req_ready;
   assign rsp_xfer      = rsp_valid && rsp_ready;
   assign req_ready     = (state_ff == tut_pkg::ST_IDLE);
   assign rsp_valid     = (state_ff == tut_pkg::ST_RESP);
   assign uid_full      = {req_uid_upper, req_uid_lower};
   assign len_sat       = (req_uid_length > 4'(UID_BYTES)) ? 4'(UID_BYTES) : req_uid_length;
   assign slot_in_range = (32'(req_slot) < ENTRIES);

   // Bytes beyond the length are stored as zero, so a longer query later
   // compares against zeros there.
   always_comb begin
      for (int k = 0; k < UID_BYTES; k++) begin
         query_in[k] = (4'(k) < len_sat)
                       ? uid_full[tut_pkg::BYTE_W*(tut_pkg::UID_FIELD_BYTES-1-k) +: 8]
                       : 8'h00;
      end
   end

   assign len_in  = len_sat;
   assign perm_in = req_permission;

   assign rd_perm = rd_data[WORD_W-1 -: 8];
   assign rd_uid  = rd_data[UID_W-1:0];

   tut_mem #(
      .DEPTH (ENTRIES),
      .WIDTH (WORD_W),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   tut_cmp #(
      .UID_BYTES (UID_BYTES)
   ) u_cmp (
      .mode             (mode_ff),
      .uid_length       (len_ff),
      .query            (query_ff),
      .entry_permission (rd_perm),
      .entry_uid        (rd_uid),
      .hit              (hit)
   );

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      idx_in      = idx_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      status_in   = status_ff;
      slot_idx_in = slot_idx_ff;
      fperm_in    = fperm_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = '0;

      unique case (state_ff)
         tut_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = tut_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         tut_pkg::ST_IDLE: begin
            if (req_xfer) begin
               idx_in      = '0;
               slot_idx_in = '0;
               fperm_in    = 8'h00;
               priority if (req_op == tut_pkg::OP_LOOKUP) begin
                  mode_in  = tut_pkg::MODE_LOOKUP;
                  state_in = tut_pkg::ST_SCAN;
               end else if (req_op == tut_pkg::OP_INSERT) begin
                  mode_in  = tut_pkg::MODE_INSERT;
                  state_in = tut_pkg::ST_SCAN;
               end else if (req_op == tut_pkg::OP_DELETE) begin
                  slot_idx_in = req_slot;
                  state_in    = tut_pkg::ST_RESP;
                  if (slot_in_range) begin
                     wr_en     = 1'b1;
                     wr_addr   = IDX_W'(req_slot);
                     status_in = tut_pkg::STATUS_OK;
                  end else begin
                     status_in = tut_pkg::STATUS_RANGE;
                  end
               end else begin
                  status_in = tut_pkg::STATUS_NOT_FOUND;
                  state_in  = tut_pkg::ST_RESP;
               end
            end
         end
         tut_pkg::ST_SCAN: begin
            // Read data is registered and arrives in the cycle after its address; chk_idx names
            // the entry whose data is on the compare unit now.
            priority if (chk_vld_ff && hit) begin
               state_in    = tut_pkg::ST_RESP;
               status_in   = tut_pkg::STATUS_OK;
               slot_idx_in = 6'(chk_idx_ff);
               if (mode_ff == tut_pkg::MODE_INSERT) begin
                  wr_en   = 1'b1;
                  wr_addr = chk_idx_ff;
                  wr_data = {perm_ff, query_ff};
               end else begin
                  fperm_in = rd_perm;
               end
            end else if (chk_vld_ff && chk_idx_ff == LAST_IDX) begin
               state_in  = tut_pkg::ST_RESP;
               status_in = (mode_ff == tut_pkg::MODE_INSERT) ? tut_pkg::STATUS_FULL
                                                             : tut_pkg::STATUS_NOT_FOUND;
            end else begin
               chk_vld_in = 1'b1;
               chk_idx_in = idx_ff;
               idx_in     = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
            end
         end
         tut_pkg::ST_RESP: begin
            if (rsp_xfer) begin
               state_in = tut_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tut_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tut_pkg::ST_CLEAR;
         idx_ff     <= '0;
         chk_vld_ff <= 1'b0;
         mode_ff    <= tut_pkg::MODE_LOOKUP;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         chk_vld_ff <= chk_vld_in;
         mode_ff    <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      status_ff   <= status_in;
      slot_idx_ff <= slot_idx_in;
      fperm_ff    <= fperm_in;
      if (req_xfer) begin
         query_ff <= query_in;
         len_ff   <= len_in;
         perm_ff  <= perm_in;
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_slot_index       = slot_idx_ff;
   assign rsp_found_permission = fperm_ff;

   // A request transfer always leads to a scan or straight to a response.
   a_req_to_work: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == tut_pkg::ST_SCAN || state_ff == tut_pkg::ST_RESP))
      else $error("request transfer did not start a scan or a response");

   // Only a successful lookup reports a permission.
   a_perm_only_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_permission != 8'h00 |-> rsp_status == tut_pkg::STATUS_OK)
      else $error("permission reported without a match");

   // A full table reports slot zero and no permission.
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tut_pkg::STATUS_FULL
      |-> rsp_slot_index == 6'd0 && rsp_found_permission == 8'h00)
      else $error("table full response carries a slot or a permission");

   // The memory is written only by the clearing sweep, a delete or an insert hit.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == tut_pkg::ST_CLEAR
               || (req_xfer && req_op == tut_pkg::OP_DELETE)
               || (state_ff == tut_pkg::ST_SCAN && mode_ff == tut_pkg::MODE_INSERT && hit))
      else $error("unexpected entry memory write");

   // After a response transfer the block takes a new request.
   a_rsp_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |=> req_ready && !rsp_valid)
      else $error("block not ready after response transfer");

endmodule

// File: sv/tut_mem.sv
// ----------------------------------------------------------------------------
// tut_mem: entry storage of the tag UID table
// One write port and one read port with registered read data. Each word
// holds the permission byte above the stored UID bytes.
// ----------------------------------------------------------------------------
module tut_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 88,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/tut_cmp.sv
// ----------------------------------------------------------------------------
// tut_cmp: entry compare unit of the tag UID table
// Checks one entry per cycle against the held request: a prefix match of
// the UID on an occupied entry for lookup, a free entry for insert.
// ----------------------------------------------------------------------------
module tut_cmp #(
   parameter int UID_BYTES = 10
) (
   input  tut_pkg::scan_mode_type      mode,
   input  logic [3:0]                  uid_length,
   input  logic [UID_BYTES-1:0][7:0]   query,
   input  logic [7:0]                  entry_permission,
   input  logic [UID_BYTES-1:0][7:0]   entry_uid,
   output logic                        hit
);

   logic [UID_BYTES-1:0] byte_ok;
   logic                 uid_match;
   logic                 occupied;

   // Bytes past the compare length always pass.
   always_comb begin
      for (int k = 0; k < UID_BYTES; k++) begin
         byte_ok[k] = (query[k] == entry_uid[k]) || (4'(k) >= uid_length);
      end
   end

   assign uid_match = &byte_ok;
   assign occupied  = (entry_permission != 8'h00);

   always_comb begin
      unique case (mode)
         tut_pkg::MODE_LOOKUP: hit = occupied && uid_match;
         tut_pkg::MODE_INSERT: hit = !occupied;
         default:              hit = 1'b0;
      endcase
   end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tag UID table
// Runs directed and random lookup, insert and delete requests through the
// request channel. A predictor keeps its own copy of the table and works out
// each response, and a monitor compares every response transfer in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         TABLE_SLOTS = 64;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [39:0] uid_upper;
      logic [39:0] uid_lower;
      logic [3:0]  uid_length;
      logic [7:0]  permission;
      logic [5:0]  slot;
      int          gap;
      bit          drain;
   } tag_request_type;

   typedef struct {
      logic [1:0] status;
      logic [5:0] slot_index;
      logic [7:0] found_permission;
   } tag_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = tut_pkg::OP_LOOKUP;
   logic [39:0] req_uid_upper = '0;
   logic [39:0] req_uid_lower = '0;
   logic [3:0]  req_uid_length = '0;
   logic [7:0]  req_permission = '0;
   logic [5:0]  req_slot = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_slot_index;
   logic [7:0]  rsp_found_permission;

   tag_uid_table DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_uid_upper        (req_uid_upper),
      .req_uid_lower        (req_uid_lower),
      .req_uid_length       (req_uid_length),
      .req_permission       (req_permission),
      .req_slot             (req_slot),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_found_permission (rsp_found_permission)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted table contents.
   logic [7:0]  slot_perm [TABLE_SLOTS];
   logic [79:0] slot_uid  [TABLE_SLOTS];

   tag_request_type  request_queue[$];
   tag_response_type expected_responses[$];
   logic [79:0]      uid_pool[16];
   int               error_count = 0;

   function automatic tag_response_type apply_table_op(tag_request_type r);
      logic [79:0]      query;
      logic [79:0]      mask;
      int               nbytes;
      int               i;
      bit               done;
      tag_response_type res;
      res    = '{tut_pkg::STATUS_NOT_FOUND, 6'd0, 8'd0};
      nbytes = (r.uid_length > tut_pkg::UID_FIELD_BYTES) ? tut_pkg::UID_FIELD_BYTES
                                                         : int'(r.uid_length);
      query  = {r.uid_upper, r.uid_lower};
      mask   = (nbytes == 0) ? '0 : ~80'd0 << (80 - 8 * nbytes);
      done   = 1'b0;
      unique case (r.op)
         tut_pkg::OP_LOOKUP: begin
            // The stored length plays no part; only the query's leading bytes count.
            for (i = 0; i < TABLE_SLOTS && !done; i++) begin
               if (slot_perm[i] != 8'd0 && ((query ^ slot_uid[i]) & mask) == '0) begin
                  res  = '{tut_pkg::STATUS_OK, i[5:0], slot_perm[i]};
                  done = 1'b1;
               end
            end
         end
         tut_pkg::OP_INSERT: begin
            res = '{tut_pkg::STATUS_FULL, 6'd0, 8'd0};
            for (i = 0; i < TABLE_SLOTS && !done; i++) begin
               if (slot_perm[i] == 8'd0) begin
                  // A zero permission writes the UID but leaves the slot free.
                  slot_uid[i]  = query & mask;
                  slot_perm[i] = r.permission;
                  res  = '{tut_pkg::STATUS_OK, i[5:0], 8'd0};
                  done = 1'b1;
               end
            end
         end
         tut_pkg::OP_DELETE: begin
            if (int'(r.slot) >= TABLE_SLOTS) begin
               res = '{tut_pkg::STATUS_RANGE, r.slot, 8'd0};
            end else begin
               slot_perm[r.slot] = 8'd0;
               slot_uid[r.slot]  = '0;
               res = '{tut_pkg::STATUS_OK, r.slot, 8'd0};
            end
         end
         default: res = '{tut_pkg::STATUS_NOT_FOUND, 6'd0, 8'd0};
      endcase
      return res;
   endfunction

   function automatic int pick_gap(bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [79:0] pick_uid();
      if ($urandom_range(0, 3) != 0)
         return uid_pool[$urandom_range(0, 15)];
      return 80'({$urandom, $urandom, $urandom});
   endfunction

   function automatic logic [3:0] pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         return 4'd0;
      else if (roll < 20)
         return 4'($urandom_range(11, 15));
      else if (roll < 35)
         return 4'($urandom_range(1, 3));
      return 4'($urandom_range(4, 10));
   endfunction

   task automatic queue_item(logic [1:0] op, logic [79:0] uid, logic [3:0] len,
                             logic [7:0] perm, logic [5:0] slot, int gap, bit drain);
      tag_request_type item;
      item.op         = op;
      item.uid_upper  = uid[79:40];
      item.uid_lower  = uid[39:0];
      item.uid_length = len;
      item.permission = perm;
      item.slot       = slot;
      item.gap        = gap;
      item.drain      = drain;
      request_queue.push_back(item);
   endtask

   // Weights are percentages for insert and lookup; the rest splits into
   // deletes and a few unused op codes.
   task automatic queue_random(int insert_pct, int lookup_pct, bit calm, bit drain);
      int          roll;
      logic [1:0]  op;
      logic [7:0]  perm;
      logic [5:0]  slot;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct)
         op = tut_pkg::OP_INSERT;
      else if (roll < insert_pct + lookup_pct)
         op = tut_pkg::OP_LOOKUP;
      else if ($urandom_range(0, 19) == 0)
         op = OP_UNUSED;
      else
         op = tut_pkg::OP_DELETE;
      perm = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      slot = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 15)) : 6'($urandom);
      queue_item(op, pick_uid(), pick_length(), perm, slot, pick_gap(calm), drain);
   endtask

   // Request driver.
   always @(posedge clock) begin : request_driver
      tag_request_type offered;
      int              in_flight;
      bit              accepted;
      bit              answered;
      if (reset) begin
         req_valid      <= 1'b0;
         req_op         <= tut_pkg::OP_LOOKUP;
         req_uid_upper  <= '0;
         req_uid_lower  <= '0;
         req_uid_length <= '0;
         req_permission <= '0;
         req_slot       <= '0;
         in_flight = 0;
      end else begin
         accepted = req_valid && req_ready;
         answered = rsp_valid && rsp_ready;
         if (accepted)
            expected_responses.push_back(apply_table_op(offered));
         in_flight = in_flight + int'(accepted) - int'(answered);
         if (!req_valid || accepted) begin
            if (request_queue.size() == 0 || (request_queue[0].drain && in_flight != 0)) begin
               req_valid <= 1'b0;
            end else if (request_queue[0].gap > 0) begin
               request_queue[0].gap = request_queue[0].gap - 1;
               req_valid <= 1'b0;
            end else begin
               offered = request_queue.pop_front();
               req_valid      <= 1'b1;
               req_op         <= offered.op;
               req_uid_upper  <= offered.uid_upper;
               req_uid_lower  <= offered.uid_lower;
               req_uid_length <= offered.uid_length;
               req_permission <= offered.permission;
               req_slot       <= offered.slot;
            end
         end
      end
   end

   // Response monitor and receiver stalls.
   always @(posedge clock) begin : response_monitor
      tag_response_type want;
      int               stall_left;
      int               calm_left;
      int               checked;
      bit               held_off;
      int               roll;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         calm_left  = 0;
         checked    = 0;
         held_off   = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $error("response transfer with no request waiting");
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_slot_index !== want.slot_index) begin
                  $error("slot_index: expected %0d, got %0d", want.slot_index,
                         rsp_slot_index);
                  error_count++;
               end
               if (rsp_found_permission !== want.found_permission) begin
                  $error("found_permission: expected %0d, got %0d",
                         want.found_permission, rsp_found_permission);
                  error_count++;
               end
            end
            checked++;
            // One long hold-off lets the table back up into the request side.
            if (checked == 150 && !held_off) begin
               held_off   = 1'b1;
               stall_left = 300;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_ready <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll == 0) begin
               calm_left = $urandom_range(40, 120);
               rsp_ready <= 1'b1;
            end else if (roll < 70) begin
               rsp_ready <= 1'b1;
            end else if (roll < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_ready <= 1'b0;
            end else begin
               stall_left = $urandom_range(8, 40);
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      logic [79:0] probe_uid;
      int          k;
      int          pos;
      for (k = 0; k < TABLE_SLOTS; k++) begin
         slot_perm[k] = 8'd0;
         slot_uid[k]  = '0;
      end
      // Pool of UIDs, many sharing a prefix so that short compares collide.
      for (k = 0; k < 16; k++) begin
         if (k < 4) begin
            uid_pool[k] = 80'({$urandom, $urandom, $urandom});
         end else begin
            uid_pool[k] = uid_pool[k % 4];
            pos = $urandom_range(3, 9);
            uid_pool[k][79 - 8 * pos -: 8] = ~uid_pool[k][79 - 8 * pos -: 8];
            uid_pool[k] = uid_pool[k] ^ 80'($urandom);
         end
      end

      probe_uid = 80'h12_34_56_78_9A_BC_DE_F0_11_22;
      queue_item(tut_pkg::OP_LOOKUP, probe_uid, 4'd10, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_INSERT, ~80'd0, 4'd10, 8'd255, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_INSERT, 80'd0, 4'd15, 8'd1, 6'd0, pick_gap(1'b0), 1'b0);
      // Zero permission: written but the slot stays free and never matches.
      queue_item(tut_pkg::OP_INSERT, probe_uid, 4'd4, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_LOOKUP, probe_uid, 4'd4, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_INSERT, probe_uid, 4'd4, 8'h80, 6'd63, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_LOOKUP, probe_uid ^ 80'hFF_FFFF, 4'd4, 8'd0, 6'd0,
                 pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_LOOKUP, probe_uid, 4'd10, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_LOOKUP, probe_uid, 4'd0, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_LOOKUP, ~80'd0, 4'd12, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_LOOKUP, 80'd0, 4'd15, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(OP_UNUSED, ~80'd0, 4'd15, 8'd255, 6'd63, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_DELETE, probe_uid, 4'd10, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_LOOKUP, probe_uid, 4'd0, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_DELETE, probe_uid, 4'd10, 8'd0, 6'd63, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_INSERT, uid_pool[0], 4'd7, 8'd42, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_LOOKUP, ~80'd0, 4'd10, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_LOOKUP, uid_pool[0], 4'd7, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_DELETE, 80'd0, 4'd0, 8'd0, 6'd1, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_DELETE, 80'd0, 4'd0, 8'd0, 6'd2, pick_gap(1'b0), 1'b0);
      queue_item(tut_pkg::OP_DELETE, 80'd0, 4'd0, 8'd0, 6'd0, pick_gap(1'b0), 1'b0);

      // Fill the table until inserts start to report it full.
      for (k = 0; k < 120; k++)
         queue_random(90, 5, 1'b0, 1'b0);
      // Mixed traffic; the first request waits until every earlier response has been taken.
      for (k = 0; k < 200; k++)
         queue_random(35, 40, 1'b0, k == 0);
      // Mostly deletes, so later inserts reuse holes low in the table.
      for (k = 0; k < 60; k++)
         queue_random(15, 15, 1'b0, 1'b0);
      for (k = 0; k < 70; k++)
         queue_random(35, 45, k < 40, k == 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge, once the driver's updates have settled.
      while (request_queue.size() != 0 || req_valid)
         @(negedge clock);
      while (expected_responses.size() != 0)
         @(negedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0)
         $display("tag_uid_table: match");
      else
         $display("tag_uid_table: mismatch");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tag_uid_table: mismatch");
      $finish;
   end

endmodule
